### hw/rtl/ptcs_pkg.sv
package ptcs_pkg;

   localparam int unsigned CellSizeWidth  = 9;
   localparam int unsigned CellSizeMin    = 32;
   localparam int unsigned CellSizeMax    = 256;
   localparam int unsigned CellSizeReset  = 64;
   localparam int unsigned LengthWidth    = 11;
   localparam int unsigned IndexWidth     = 6;
   localparam int unsigned MaxCellIndex   = 63;
   localparam int unsigned QueueWidth     = 9;
   localparam int unsigned FlowWidth      = 10;

   // descriptor queue between front and back
   localparam int unsigned FifoDepth      = 2;
   localparam int unsigned FifoPtrWidth   = $clog2(FifoDepth);
   localparam int unsigned FifoCountWidth = $clog2(FifoDepth + 1);

   // classified descriptor, as held in the queue
   typedef struct packed {
      logic [7:0]               source_id;
      logic [7:0]               dest_id;
      logic [2:0]               priority_req;
      logic [15:0]              frame_seq;
      logic [LengthWidth-1:0]   packet_length;
      logic [QueueWidth-1:0]    queue_number;
      logic [CellSizeWidth-1:0] cell_size;
   } desc_type;

   typedef struct packed {
      logic [7:0]               cell_source_id;
      logic [7:0]               cell_dest_id;
      logic [2:0]               cell_priority;
      logic [15:0]              cell_frame_seq;
      logic [LengthWidth-1:0]   cell_packet_length;
      logic [QueueWidth-1:0]    queue_number;
      logic [FlowWidth-1:0]     flow_number;
      logic [CellSizeWidth-1:0] valid_bytes;
      logic [IndexWidth-1:0]    cell_index;
      logic                     last_cell;
   } cell_type;

endpackage

### hw/rtl/ptcs_front.sv
module ptcs_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ptcs_pkg::CellSizeWidth-1:0]   csr_write_data,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_source_id,
   input  logic [7:0]                           req_dest_id,
   input  logic [2:0]                           req_priority_req,
   input  logic [15:0]                          req_frame_seq,
   input  logic [ptcs_pkg::LengthWidth-1:0]     req_packet_length,
   input  logic                                 fifo_full,
   output logic                                 fifo_push,
   output ptcs_pkg::desc_type                   fifo_desc
);

   logic [ptcs_pkg::CellSizeWidth-1:0] cell_size_ff, cell_size_in;
   logic [ptcs_pkg::CellSizeWidth-1:0] cell_size_eff;

   always_comb begin
      cell_size_in = csr_write_en ? csr_write_data : cell_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= ptcs_pkg::CellSizeWidth'(ptcs_pkg::CellSizeReset);
      end else begin
         cell_size_ff <= cell_size_in;
      end
   end

   // clamp into the legal cell size range
   always_comb begin
      if (cell_size_ff < ptcs_pkg::CellSizeWidth'(ptcs_pkg::CellSizeMin)) begin
         cell_size_eff = ptcs_pkg::CellSizeWidth'(ptcs_pkg::CellSizeMin);
      end else if (cell_size_ff > ptcs_pkg::CellSizeWidth'(ptcs_pkg::CellSizeMax)) begin
         cell_size_eff = ptcs_pkg::CellSizeWidth'(ptcs_pkg::CellSizeMax);
      end else begin
         cell_size_eff = cell_size_ff;
      end
   end

   always_comb begin
      req_full                = fifo_full;
      fifo_push               = req_push && !fifo_full;
      fifo_desc.source_id     = req_source_id;
      fifo_desc.dest_id       = req_dest_id;
      fifo_desc.priority_req  = req_priority_req;
      fifo_desc.frame_seq     = req_frame_seq;
      fifo_desc.packet_length = req_packet_length;
      fifo_desc.queue_number  = ptcs_pkg::QueueWidth'(req_source_id)
                              + ptcs_pkg::QueueWidth'(req_dest_id);
      fifo_desc.cell_size     = cell_size_eff;
   end

endmodule

### hw/rtl/ptcs_desc_fifo.sv
module ptcs_desc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ptcs_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ptcs_pkg::desc_type head_desc
);

   logic [ptcs_pkg::FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ptcs_pkg::FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ptcs_pkg::FifoCountWidth-1:0] count_ff, count_in;
   ptcs_pkg::desc_type                  entry_ff [ptcs_pkg::FifoDepth];

   always_comb begin
      full      = count_ff == ptcs_pkg::FifoCountWidth'(ptcs_pkg::FifoDepth);
      empty     = count_ff == '0;
      head_desc = entry_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ptcs_pkg::FifoPtrWidth'(ptcs_pkg::FifoDepth - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ptcs_pkg::FifoPtrWidth'(ptcs_pkg::FifoDepth - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("descriptor queue popped while empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("descriptor queue pushed while full");

endmodule

### hw/rtl/ptcs_back.sv
module ptcs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_empty,
   input  ptcs_pkg::desc_type fifo_desc,
   output logic               fifo_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ptcs_pkg::cell_type rsp_cell
);

   logic                                busy_ff, busy_in;
   ptcs_pkg::desc_type                  cur_ff, cur_in;
   logic [ptcs_pkg::LengthWidth-1:0]    rem_ff, rem_in;
   logic [ptcs_pkg::IndexWidth-1:0]     index_ff, index_in;
   logic                                out_valid_ff, out_valid_in;
   ptcs_pkg::cell_type                  cell_ff, cell_in;

   logic advance;
   logic emit;
   logic full_cell;
   logic load;

   always_comb begin
      advance   = !out_valid_ff || rsp_pop;
      emit      = busy_ff && advance;
      // full cell while more than one cell's worth remains, capped at the last index
      full_cell = (rem_ff > ptcs_pkg::LengthWidth'(cur_ff.cell_size))
               && (index_ff != ptcs_pkg::IndexWidth'(ptcs_pkg::MaxCellIndex));
      load      = !fifo_empty && (!busy_ff || (emit && !full_cell));
      fifo_pop  = load;
   end

   always_comb begin
      busy_in  = busy_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      index_in = index_ff;
      if (load) begin
         busy_in  = 1'b1;
         cur_in   = fifo_desc;
         rem_in   = fifo_desc.packet_length;
         index_in = '0;
      end else if (emit) begin
         if (full_cell) begin
            rem_in   = rem_ff - ptcs_pkg::LengthWidth'(cur_ff.cell_size);
            index_in = index_ff + 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      cell_in      = cell_ff;
      if (emit) begin
         out_valid_in               = 1'b1;
         cell_in.cell_source_id     = cur_ff.source_id;
         cell_in.cell_dest_id       = cur_ff.dest_id;
         cell_in.cell_priority      = cur_ff.priority_req;
         cell_in.cell_frame_seq     = cur_ff.frame_seq;
         cell_in.cell_packet_length = cur_ff.packet_length;
         cell_in.queue_number       = cur_ff.queue_number;
         cell_in.flow_number        = {cur_ff.queue_number, 1'b0};
         cell_in.valid_bytes        = full_cell ? cur_ff.cell_size
                                    : rem_ff[ptcs_pkg::CellSizeWidth-1:0];
         cell_in.cell_index         = index_ff;
         cell_in.last_cell          = !full_cell;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      rem_ff   <= rem_in;
      index_ff <= index_in;
      cell_ff  <= cell_in;
   end

   always_comb begin
      rsp_empty = !out_valid_ff;
      rsp_cell  = cell_ff;
   end

   a_full_cell_min_size: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !cell_ff.last_cell)
      |-> (cell_ff.valid_bytes >= ptcs_pkg::CellSizeWidth'(ptcs_pkg::CellSizeMin)))
      else $error("non-final cell shorter than minimum cell size");

   a_last_index_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && cell_ff.cell_index == ptcs_pkg::IndexWidth'(ptcs_pkg::MaxCellIndex))
      |-> cell_ff.last_cell)
      else $error("cell at the final index not marked last");

   a_stall_holds_position: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !advance) |=> ($stable(index_ff) && $stable(rem_ff)))
      else $error("segmentation position moved during output stall");

endmodule

### hw/rtl/packet_to_cell_segmenter.sv
// First cell path: queue entry, current-descriptor register, output cell register, rsp_ ports.
// Throughput: one cell per cycle from the cell generator while the output is popped; a packet
//   has 1..64 cells, and the next packet's first cell follows its last cell directly if queued.
// A two-entry descriptor queue lets requests land while the generator is busy.
// Reset (synchronous, active high): queue and output register empty, cell size 64.
module packet_to_cell_segmenter (
   input  logic                               clock,
   input  logic                               reset,

   // configuration: cell size register
   input  logic                               csr_write_en,
   input  logic [ptcs_pkg::CellSizeWidth-1:0] csr_write_data,

   // packet descriptor request queue side
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [7:0]                         req_source_id,
   input  logic [7:0]                         req_dest_id,
   input  logic [2:0]                         req_priority_req,
   input  logic [15:0]                        req_frame_seq,
   input  logic [ptcs_pkg::LengthWidth-1:0]   req_packet_length,

   // cell response queue side
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [7:0]                         rsp_cell_source_id,
   output logic [7:0]                         rsp_cell_dest_id,
   output logic [2:0]                         rsp_cell_priority,
   output logic [15:0]                        rsp_cell_frame_seq,
   output logic [ptcs_pkg::LengthWidth-1:0]   rsp_cell_packet_length,
   output logic [ptcs_pkg::QueueWidth-1:0]    rsp_queue_number,
   output logic [ptcs_pkg::FlowWidth-1:0]     rsp_flow_number,
   output logic [ptcs_pkg::CellSizeWidth-1:0] rsp_valid_bytes,
   output logic [ptcs_pkg::IndexWidth-1:0]    rsp_cell_index,
   output logic                               rsp_last_cell
);

   logic               fifo_full;
   logic               fifo_push;
   logic               fifo_pop;
   logic               fifo_empty;
   ptcs_pkg::desc_type push_desc;
   ptcs_pkg::desc_type head_desc;
   ptcs_pkg::cell_type rsp_cell;

   // Front: holds the cell size register, clamps it to 32..256 and tags each
   // descriptor with its queue id and the cell size in force at acceptance.
   ptcs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_id     (req_source_id),
      .req_dest_id       (req_dest_id),
      .req_priority_req  (req_priority_req),
      .req_frame_seq     (req_frame_seq),
      .req_packet_length (req_packet_length),
      .fifo_full         (fifo_full),
      .fifo_push         (fifo_push),
      .fifo_desc         (push_desc)
   );

   // Short descriptor queue decoupling acceptance from cell generation.
   ptcs_desc_fifo u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_desc (push_desc),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .empty     (fifo_empty),
      .head_desc (head_desc)
   );

   // Back: walks the remaining length one cell per cycle into an output register while
   // it is free or popped; the next descriptor loads on the cycle the last cell goes out.
   ptcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_desc  (head_desc),
      .fifo_pop   (fifo_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_cell   (rsp_cell)
   );

   always_comb begin
      rsp_cell_source_id     = rsp_cell.cell_source_id;
      rsp_cell_dest_id       = rsp_cell.cell_dest_id;
      rsp_cell_priority      = rsp_cell.cell_priority;
      rsp_cell_frame_seq     = rsp_cell.cell_frame_seq;
      rsp_cell_packet_length = rsp_cell.cell_packet_length;
      rsp_queue_number       = rsp_cell.queue_number;
      rsp_flow_number        = rsp_cell.flow_number;
      rsp_valid_bytes        = rsp_cell.valid_bytes;
      rsp_cell_index         = rsp_cell.cell_index;
      rsp_last_cell          = rsp_cell.last_cell;
   end

endmodule
